// ===== hw/rtl/qmn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared widths, types and constants of the normalized quaternion product.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int CompBits  = 16;
  localparam int FracBits  = 14;
  // four-term sum of 16x16 products
  localparam int SumBits   = 2 * CompBits + 2;
  localparam int MagBits   = SumBits - 1;
  localparam int TopBit    = 29;
  localparam int NormBits  = TopBit + 1;
  localparam int SqBits    = 2 * NormBits + 2;
  localparam int RootBits  = NormBits + 1;
  // spare top bit: the rounding term can carry past mag * 2^frac
  localparam int NumBits   = NormBits + FracBits + 1;
  localparam int QuoBits   = NumBits;
  localparam int ShBits    = 6;

  localparam logic [CompBits-1:0] Limit = CompBits'(
      ((1 << FracBits) < ((1 << (CompBits - 1)) - 1)) ?
      (1 << FracBits) : ((1 << (CompBits - 1)) - 1));

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic signed [SumBits-1:0]  sum_t;
  typedef logic [MagBits-1:0]         mag_t;
  typedef logic [NormBits-1:0]        norm_t;

endpackage

// ===== hw/rtl/quaternion_multiply_normalise.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_normalise
// Hamilton product right*left of two Q2.14 quaternions, scaled to unit length.
// Pipeline: product stages, square root, divide, then the output register.
// Throughput: one transfer per cycle; the whole pipe stalls only when the
// output register is full and not taken. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalise (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [qmn_pkg::CompBits-1:0]  left_w_i,
  input  logic [qmn_pkg::CompBits-1:0]  left_x_i,
  input  logic [qmn_pkg::CompBits-1:0]  left_y_i,
  input  logic [qmn_pkg::CompBits-1:0]  left_z_i,
  input  logic [qmn_pkg::CompBits-1:0]  right_w_i,
  input  logic [qmn_pkg::CompBits-1:0]  right_x_i,
  input  logic [qmn_pkg::CompBits-1:0]  right_y_i,
  input  logic [qmn_pkg::CompBits-1:0]  right_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qmn_pkg::CompBits-1:0]  prod_w_o,
  output logic [qmn_pkg::CompBits-1:0]  prod_x_o,
  output logic [qmn_pkg::CompBits-1:0]  prod_y_o,
  output logic [qmn_pkg::CompBits-1:0]  prod_z_o,
  output logic                          zero_length_o
);
  localparam int SB = qmn_pkg::SumBits;
  localparam int MB = qmn_pkg::MagBits;
  localparam int NB = qmn_pkg::NormBits;
  localparam int PB = 2 * qmn_pkg::CompBits;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: sixteen products
  logic               v1_q;
  logic signed [PB-1:0] pr_q [16];
  qmn_pkg::comp_t l [4];
  qmn_pkg::comp_t r [4];
  assign l = '{left_w_i, left_x_i, left_y_i, left_z_i};
  assign r = '{right_w_i, right_x_i, right_y_i, right_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          pr_q[4*a+b] <= l[a] * r[b];
        end
      end
    end
  end

  // stage 2: four sums (index 4*left + right)
  logic v2_q;
  qmn_pkg::sum_t p_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= SB'(pr_q[0])  - SB'(pr_q[5])  - SB'(pr_q[10]) - SB'(pr_q[15]);
      p_q[1] <= SB'(pr_q[14]) - SB'(pr_q[11]) + SB'(pr_q[1])  + SB'(pr_q[4]);
      p_q[2] <= SB'(pr_q[7])  - SB'(pr_q[13]) + SB'(pr_q[2])  + SB'(pr_q[8]);
      p_q[3] <= SB'(pr_q[9])  - SB'(pr_q[6])  + SB'(pr_q[3])  + SB'(pr_q[12]);
    end
  end

  // stage 3: magnitudes, signs, OR of magnitudes for the top bit
  logic v3_q;
  qmn_pkg::mag_t mag3_q [4];
  logic [3:0] neg3_q;
  qmn_pkg::mag_t or3_d;
  always_comb begin
    or3_d = '0;
    for (int i = 0; i < 4; i++) begin
      or3_d = or3_d | MB'(p_q[i][SB-1] ? -p_q[i] : p_q[i]);
    end
  end
  qmn_pkg::mag_t orr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      orr_q <= or3_d;
      for (int i = 0; i < 4; i++) begin
        neg3_q[i] <= p_q[i][SB-1];
        mag3_q[i] <= MB'(p_q[i][SB-1] ? -p_q[i] : p_q[i]);
      end
    end
  end

  // stage 4: leading one of the OR equals that of the maximum; shift amount
  logic v4_q;
  qmn_pkg::mag_t mag4_q [4];
  logic [3:0] neg4_q;
  logic [qmn_pkg::ShBits-1:0] bits4_q;
  logic zero4_q;
  logic [qmn_pkg::ShBits-1:0] bits_d;
  always_comb begin
    bits_d = '0;
    for (int b = 0; b < MB; b++) begin
      if (orr_q[b]) bits_d = qmn_pkg::ShBits'(b + 1);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      bits4_q <= bits_d;
      zero4_q <= (orr_q == '0);
    end
  end

  // stage 5: normalize so the max has its top bit at bit 29
  logic v5_q;
  logic [3:0][NB-1:0] n5_q;
  logic [3:0] neg5_q;
  logic zero5_q;
  logic [3:0][NB-1:0] n_d;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (bits4_q > qmn_pkg::ShBits'(NB)) begin
        n_d[i] = NB'(mag4_q[i] >> (bits4_q - qmn_pkg::ShBits'(NB)));
      end else begin
        n_d[i] = NB'(mag4_q[i] << (qmn_pkg::ShBits'(NB) - bits4_q));
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q    <= n_d;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // stage 6: squares (30x30), then sum
  logic v6_q;
  logic [3:0][2*NB-1:0] sq6_q;
  logic [3:0][NB-1:0] n6_q;
  logic [3:0] neg6_q;
  logic zero6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq6_q[i] <= n5_q[i] * n5_q[i];
      end
      n6_q    <= n5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  logic [qmn_pkg::SqBits-1:0] rad;
  assign rad = qmn_pkg::SqBits'(sq6_q[0]) + qmn_pkg::SqBits'(sq6_q[1]) +
               qmn_pkg::SqBits'(sq6_q[2]) + qmn_pkg::SqBits'(sq6_q[3]);

  logic v7;
  logic [qmn_pkg::RootBits-1:0] root7;
  logic [3:0][NB-1:0] n7;
  logic [3:0] neg7;
  logic zero7;

  qmn_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v6_q), .rad_i(rad), .mag_i(n6_q), .neg_i(neg6_q), .zero_i(zero6_q),
    .valid_o(v7), .root_o(root7), .mag_o(n7), .neg_o(neg7), .zero_o(zero7)
  );

  logic v8;
  logic [3:0][qmn_pkg::CompBits-1:0] comp8;
  logic zero8;

  qmn_divide u_divide (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v7), .root_i(root7), .mag_i(n7), .neg_i(neg7), .zero_i(zero7),
    .valid_o(v8), .comp_o(comp8), .zero_o(zero8)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v8;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_w_o      <= comp8[0];
      prod_x_o      <= comp8[1];
      prod_y_o      <= comp8[2];
      prod_z_o      <= comp8[3];
      zero_length_o <= zero8;
    end
  end
  assign out_valid_o = out_valid_q;

  // zero-length results carry all-zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      prod_w_o == '0 && prod_x_o == '0 && prod_y_o == '0 && prod_z_o == '0)
    else $error("zero-length result with nonzero components");

  // a stalled output never accepts input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // a stall freezes the first pipeline stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q))
    else $error("pipeline moved during stall");
endmodule

// ===== hw/rtl/qmn_isqrt.sv =====
// ----------------------------------------------------------------------------
// qmn_isqrt
// Pipelined integer square root, one result bit per stage, advancing while en_i is high.
// Carries the sign bits, normalized magnitudes and zero flag alongside.
// ----------------------------------------------------------------------------
module qmn_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [qmn_pkg::SqBits-1:0]        rad_i,
  input  logic [3:0][qmn_pkg::NormBits-1:0] mag_i,
  input  logic [3:0]                        neg_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  output logic [qmn_pkg::RootBits-1:0]      root_o,
  output logic [3:0][qmn_pkg::NormBits-1:0] mag_o,
  output logic [3:0]                        neg_o,
  output logic                              zero_o
);
  localparam int Steps = qmn_pkg::RootBits;
  localparam int SB    = qmn_pkg::SqBits;
  localparam int RB    = qmn_pkg::RootBits;

  logic [Steps:0]                        v_q;
  logic [Steps:0][SB-1:0]                rem_q;
  logic [Steps:0][RB-1:0]                res_q;
  logic [Steps:0][3:0][qmn_pkg::NormBits-1:0] mag_q;
  logic [Steps:0][3:0]                   neg_q;
  logic [Steps:0]                        zero_q;

  always_comb begin
    v_q[0]    = valid_i;
    rem_q[0]  = rad_i;
    res_q[0]  = '0;
    mag_q[0]  = mag_i;
    neg_q[0]  = neg_i;
    zero_q[0] = zero_i;
  end

  // stage s decides root bit Steps-1-s by restoring trial subtraction
  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int Bit = Steps - 1 - s;
    logic [SB:0]   trial;
    logic [SB-1:0] rem_d;
    logic [RB-1:0] res_d;
    always_comb begin
      trial = {1'b0, rem_q[s]} -
              (((SB+1)'(res_q[s]) << (Bit + 1)) | ((SB+1)'(1) << (2 * Bit)));
      if (!trial[SB]) begin
        rem_d = trial[SB-1:0];
        res_d = res_q[s] | (RB'(1) << Bit);
      end else begin
        rem_d = rem_q[s];
        res_d = res_q[s];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        res_q[s+1]  <= res_d;
        mag_q[s+1]  <= mag_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign root_o  = res_q[Steps];
  assign mag_o   = mag_q[Steps];
  assign neg_o   = neg_q[Steps];
  assign zero_o  = zero_q[Steps];
endmodule

// ===== hw/rtl/qmn_divide.sv =====
// ----------------------------------------------------------------------------
// qmn_divide
// Four pipelined restoring dividers, one quotient bit per stage, with
// rounding, clamping and sign restore at the end.
// ----------------------------------------------------------------------------
module qmn_divide (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [qmn_pkg::RootBits-1:0]      root_i,
  input  logic [3:0][qmn_pkg::NormBits-1:0] mag_i,
  input  logic [3:0]                        neg_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  output logic [3:0][qmn_pkg::CompBits-1:0] comp_o,
  output logic                              zero_o
);
  localparam int NB    = qmn_pkg::NumBits;
  localparam int RB    = qmn_pkg::RootBits;
  localparam int Steps = qmn_pkg::QuoBits;
  localparam int WB    = NB + 1;

  logic [RB-1:0] root_fix;
  logic [NB-1:0] num0 [4];

  // numerator = mag * 2^frac + floor(L/2), zero root treated as one
  always_comb begin
    root_fix = (root_i == '0) ? RB'(1) : root_i;
    for (int i = 0; i < 4; i++) begin
      num0[i] = (NB'(mag_i[i]) << qmn_pkg::FracBits) + NB'(root_fix >> 1);
    end
  end

  logic [Steps:0]                v_q;
  logic [Steps:0][RB-1:0]        den_q;
  logic [Steps:0][3:0][WB-1:0]   rem_q;
  logic [Steps:0][3:0][NB-1:0]   quo_q;
  logic [Steps:0][3:0]           neg_q;
  logic [Steps:0]                zero_q;

  always_comb begin
    v_q[0]    = valid_i;
    den_q[0]  = root_fix;
    neg_q[0]  = neg_i;
    zero_q[0] = zero_i;
    for (int i = 0; i < 4; i++) begin
      rem_q[0][i] = '0;
      quo_q[0][i] = num0[i];
    end
  end

  // shift-subtract: quotient bits enter at the bottom of quo
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [3:0][WB-1:0] rem_d;
    logic [3:0][NB-1:0] quo_d;
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        logic [WB-1:0] sh;
        sh = {rem_q[s][i][WB-2:0], quo_q[s][i][NB-1]};
        if (sh >= WB'(den_q[s])) begin
          rem_d[i] = sh - WB'(den_q[s]);
          quo_d[i] = {quo_q[s][i][NB-2:0], 1'b1};
        end else begin
          rem_d[i] = sh;
          quo_d[i] = {quo_q[s][i][NB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1]  <= den_q[s];
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= quo_d;
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  // clamp, restore sign, force zero on zero-length
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [qmn_pkg::CompBits-1:0] q;
      q = (quo_q[Steps][i] > NB'(qmn_pkg::Limit)) ? qmn_pkg::Limit
                                                  : quo_q[Steps][i][qmn_pkg::CompBits-1:0];
      if (zero_q[Steps]) begin
        comp_o[i] = '0;
      end else if (neg_q[Steps][i]) begin
        comp_o[i] = -q;
      end else begin
        comp_o[i] = q;
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign zero_o  = zero_q[Steps];
endmodule
